[hdl/pnp_pkg.sv]
// Package for the pixel normalizer and planarizer: types, constants and helpers.
// Used by every module of the block; it depends on nothing else.
package pnp_pkg;

    // Frame size limits and field widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int DIM_W      = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CMP_W      = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int PITCH_W    = 13;
    localparam int BYTE_W     = 8;
    localparam int NORM_W     = 40;
    localparam int MEAN_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int ADDR_W     = 24;
    localparam int VALUE_W    = 32;
    localparam int DIFF_W     = BYTE_W + 8 + 1;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int FRAC_SHIFT = 12;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam logic [CH_W-1:0] CH_FIRST = CH_W'(0);
    localparam logic [CH_W-1:0] CH_LAST  = CH_W'(NUM_CH - 1);

    // Queue between the front and the back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Layout register bits.
    localparam int LAYOUT_SWAP_BIT   = 0;
    localparam int LAYOUT_PLANAR_BIT = 1;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORM0,
        CFG_NORM1,
        CFG_NORM2,
        CFG_LAYOUT,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_PITCH
    } t_cfg_idx;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(640);
    localparam logic [PITCH_W-1:0] RST_PITCH  = PITCH_W'(1920);

    // One input pixel as stored in memory.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_zero;
        logic [BYTE_W-1:0] byte_one;
        logic [BYTE_W-1:0] byte_two;
    } t_pixel;

    // One normalized channel value with its destination.
    typedef struct packed {
        logic [ADDR_W-1:0]         element_address;
        logic signed [VALUE_W-1:0] channel_value;
        logic [CH_W-1:0]           channel_index;
        logic                      last_of_pixel;
        logic                      frame_end;
    } t_result;

    // Configuration as seen by the front and back end, sizes already clamped.
    typedef struct packed {
        logic [NUM_CH-1:0][NORM_W-1:0] norm;
        logic                          swap;
        logic                          planar;
        logic [DIM_W-1:0]              width;
        logic [DIM_W-1:0]              height;
        logic [PITCH_W-1:0]            pitch;
    } t_cfg;

    // A classified pixel waiting for the back end.
    typedef struct packed {
        logic [NUM_CH-1:0][BYTE_W-1:0] chan_byte;
        logic [COL_W-1:0]              col;
        logic [ROW_W-1:0]              row;
        logic                          frame_end;
    } t_job;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Clamp a frame dimension to 1..maxv; zero acts as one.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end
        return r;
    endfunction

endpackage

[hdl/pnp_front.sv]
// Front end: accepts pixels, orders their bytes per channel and tracks the raster position.
// Depends on pnp_pkg; feeds pnp_queue.
module pnp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pnp_pkg::t_pixel    i_pixel,
    input  pnp_pkg::t_cfg      i_cfg,
    input  pnp_pkg::t_q_status i_q_status,
    output logic               o_push,
    output pnp_pkg::t_job      o_job
);
    import pnp_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             col_last;
    logic             row_last;
    logic             accept;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // End of row and end of frame tests, also true past a shrunken size.
    assign col_last = CMP_W'(r_col) >= (CMP_W'(i_cfg.width) - CMP_W'(1));
    assign row_last = CMP_W'(r_row) >= (CMP_W'(i_cfg.height) - CMP_W'(1));

    // Build the job: bytes in output channel order plus position.
    always_comb begin
        o_job.chan_byte[1] = i_pixel.byte_one;
        if (i_cfg.swap) begin
            o_job.chan_byte[0] = i_pixel.byte_two;
            o_job.chan_byte[2] = i_pixel.byte_zero;
        end else begin
            o_job.chan_byte[0] = i_pixel.byte_zero;
            o_job.chan_byte[2] = i_pixel.byte_two;
        end
        o_job.col       = r_col;
        o_job.row       = r_row;
        o_job.frame_end = col_last && row_last;
    end

    // Raster counters advance once per accepted pixel.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : ROW_W'(r_row + ROW_W'(1));
            end else begin
                n_col = COL_W'(r_col + COL_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[hdl/pnp_queue.sv]
// Short job queue that decouples the front end from the back end.
// Depends on pnp_pkg.
module pnp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pnp_pkg::t_job      i_job,
    input  logic               i_pop,
    output pnp_pkg::t_q_status o_status,
    output pnp_pkg::t_job      o_job
);
    import pnp_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;

    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= Q_AW'(r_wptr + Q_AW'(1));
            end
            if (i_pop) begin
                r_rptr <= Q_AW'(r_rptr + Q_AW'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= Q_CW'(r_count + Q_CW'(1));
            end else if (i_pop && !i_push) begin
                r_count <= Q_CW'(r_count - Q_CW'(1));
            end
        end
    end

endmodule

[hdl/pnp_back.sv]
// Back end: steps through the three channels of each job, computing address and value.
// Depends on pnp_pkg; drains pnp_queue and owns the output register.
module pnp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pnp_pkg::t_cfg      i_cfg,
    input  pnp_pkg::t_q_status i_q_status,
    input  pnp_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output pnp_pkg::t_result   o_result
);
    import pnp_pkg::*;

    logic                          r_busy;
    logic [CH_W-1:0]               r_ch;
    logic [NUM_CH-1:0][BYTE_W-1:0] r_bytes;
    logic                          r_frame_end;
    logic [ADDR_W-1:0]             r_addr;
    logic [ADDR_W-1:0]             r_plane;
    logic                          r_out_valid;
    t_result                       r_out;

    logic                      emit;
    logic                      last;
    logic [PITCH_W-1:0]        row_mul;
    logic [ADDR_W-1:0]         col_term;
    logic [ADDR_W-1:0]         base;
    logic [ADDR_W-1:0]         addr_step;
    logic [BYTE_W-1:0]         src_byte;
    logic [NORM_W-1:0]         norm;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SCALE_W-1:0] scale;
    logic signed [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0]        value;

    // Sequencer handshake: one channel per cycle while the output can take it.
    assign emit  = r_busy && (!r_out_valid || i_ready);
    assign last  = (r_ch == CH_LAST);
    assign o_pop = !i_q_status.empty && (!r_busy || (emit && last));

    // Start address of a job: row times stride plus the column offset.
    always_comb begin
        if (i_cfg.planar) begin
            row_mul  = PITCH_W'(i_cfg.width);
            col_term = ADDR_W'(i_job.col);
        end else begin
            row_mul  = i_cfg.pitch;
            col_term = ADDR_W'(i_job.col) + (ADDR_W'(i_job.col) << 1);
        end
        base = ADDR_W'(ADDR_W'(i_job.row) * ADDR_W'(row_mul)) + col_term;
    end

    // Between channels the address moves by one plane or by one element.
    assign addr_step = i_cfg.planar ? r_plane : ADDR_W'(1);

    // Channel operands.
    always_comb begin
        case (r_ch)
            2'd0: begin
                src_byte = r_bytes[0];
                norm     = i_cfg.norm[0];
            end
            2'd1: begin
                src_byte = r_bytes[1];
                norm     = i_cfg.norm[1];
            end
            2'd2: begin
                src_byte = r_bytes[2];
                norm     = i_cfg.norm[2];
            end
            default: begin
                src_byte = '0;
                norm     = '0;
            end
        endcase
    end

    // Mean subtraction, scaling and floor shift down to Q16.16.
    always_comb begin
        diff  = $signed({1'b0, src_byte, 8'h00}) -
                $signed({1'b0, norm[NORM_W-1 -: MEAN_W]});
        scale = $signed(norm[SCALE_W-1:0]);
        prod  = PROD_W'(diff) * PROD_W'(scale);
        value = {{(VALUE_W - (PROD_W - FRAC_SHIFT)){prod[PROD_W-1]}},
                 prod[PROD_W-1:FRAC_SHIFT]};
    end

    // Plane size follows the configuration.
    always_ff @(posedge i_clk) begin
        r_plane <= ADDR_W'(i_cfg.height) * ADDR_W'(i_cfg.width);
    end

    // Job registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes     <= i_job.chan_byte;
            r_frame_end <= i_job.frame_end;
            r_addr      <= base;
        end else if (emit) begin
            r_addr <= ADDR_W'(r_addr + addr_step);
        end
    end

    // Channel sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ch   <= CH_FIRST;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_ch   <= CH_FIRST;
        end else if (emit) begin
            r_busy <= !last;
            r_ch   <= last ? CH_FIRST : CH_W'(r_ch + CH_W'(1));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.element_address <= r_addr;
            r_out.channel_value   <= $signed(value);
            r_out.channel_index   <= r_ch;
            r_out.last_of_pixel   <= last;
            r_out.frame_end       <= last && r_frame_end;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hdl/pixel_normalize_and_planarize.sv]
// Top level of the pixel normalizer and planarizer: configuration registers and wiring.
// Depends on pnp_pkg, pnp_front, pnp_queue and pnp_back.

// Each accepted three-byte pixel produces three results, channel 0, 1 and 2 in that
// order, each carrying a Q16.16 value and its destination element address (planar or
// interleaved layout). The back end's channel sequencer emits one result per cycle
// while the output can take it, and takes the next pixel's job with its last channel.
// A pixel passes through the queue, the job registers and the output register before
// its first result appears. A two-entry queue sits between the pixel input and the
// sequencer, and the output is registered, so new pixels are taken while results wait.
// Configuration writes also reach queued pixels and must be made while the block is idle.
module pixel_normalize_and_planarize (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pnp_pkg::t_pixel                     i_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output pnp_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pnp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pnp_pkg::NORM_W-1:0]          i_cfg_data
);
    import pnp_pkg::*;

    logic [NUM_CH-1:0][NORM_W-1:0] r_norm;
    logic [1:0]                    r_layout;
    logic [DIM_W-1:0]              r_width;
    logic [DIM_W-1:0]              r_height;
    logic [PITCH_W-1:0]            r_pitch;

    t_cfg      cfg;
    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm   <= '0;
            r_layout <= '0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_pitch  <= RST_PITCH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NORM0:  r_norm[0] <= i_cfg_data;
                CFG_NORM1:  r_norm[1] <= i_cfg_data;
                CFG_NORM2:  r_norm[2] <= i_cfg_data;
                CFG_LAYOUT: r_layout  <= i_cfg_data[1:0];
                CFG_WIDTH:  r_width   <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[DIM_W-1:0];
                CFG_PITCH:  r_pitch   <= i_cfg_data[PITCH_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective configuration with frame sizes clamped to the supported range.
    always_comb begin
        cfg.norm   = r_norm;
        cfg.swap   = r_layout[LAYOUT_SWAP_BIT];
        cfg.planar = r_layout[LAYOUT_PLANAR_BIT];
        cfg.width  = clamp_dim(r_width, MAX_WIDTH);
        cfg.height = clamp_dim(r_height, MAX_HEIGHT);
        cfg.pitch  = r_pitch;
    end

    pnp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel    (i_pixel),
        .i_cfg      (cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    pnp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_status (q_status),
        .o_job    (head_job)
    );

    pnp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_status (q_status),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    // The last-of-pixel flag marks exactly the final channel.
    a_last_marks_final_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last_of_pixel == (o_result.channel_index == CH_LAST)))
        else $error("last_of_pixel does not match the channel index");

    // A frame end only ever comes with the last channel of a pixel.
    a_frame_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.frame_end) |-> o_result.last_of_pixel)
        else $error("frame_end on a result that is not the last of its pixel");

    // After channel 0 is taken the next result shown is channel 1.
    a_channel_order_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && (o_result.channel_index == CH_FIRST))
        |=> (!o_valid || (o_result.channel_index == CH_W'(1))))
        else $error("channel 1 did not follow channel 0");

    // A queue that is full never accepts a new request.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !(i_valid && o_ready))
        else $error("pixel request accepted with the queue full");

endmodule

[test/pnp_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the pixel normalizer and planarizer: follows the request channels,
// predicts each pixel's three channel values and addresses, and compares. Depends on pnp_pkg.
module pnp_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pix_valid,
    input  logic                            i_pix_ready,
    input  pnp_pkg::t_pixel                 i_pixel,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  pnp_pkg::t_result                i_result,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [pnp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pnp_pkg::NORM_W-1:0]      i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);
    import pnp_pkg::*;

    // Shadow copy of the block's registers and raster counters.
    logic [NORM_W-1:0]  cfg_norm [NUM_CH];
    logic               cfg_swap;
    logic               cfg_planar;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [PITCH_W-1:0] cfg_pitch;
    int                 col_count;
    int                 row_count;

    t_result expected_results[$];
    t_result want;
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // A dimension of zero acts as one; anything above the maximum is clipped.
    function automatic int effective_dim(input logic [DIM_W-1:0] dim, input int max_dim);
        if (dim == '0) return 1;
        if (int'(dim) > max_dim) return max_dim;
        return int'(dim);
    endfunction

    // (byte as Q8.8 minus the mean) times the Q4.20 scale, floored down to Q16.16.
    function automatic logic signed [VALUE_W-1:0] normalized_value(input logic [BYTE_W-1:0] b,
                                                                   input logic [NORM_W-1:0] norm);
        longint mean;
        longint scale;
        longint diff;
        mean  = longint'(norm[NORM_W-1:SCALE_W]);
        scale = longint'($signed(norm[SCALE_W-1:0]));
        diff  = longint'({b, 8'h00}) - mean;
        return VALUE_W'((diff * scale) >>> FRAC_SHIFT);
    endfunction

    // Queue the three results of one pixel and advance the raster position.
    function automatic void predict_channels(input t_pixel px);
        logic [BYTE_W-1:0] bytes [NUM_CH];
        logic [BYTE_W-1:0] src;
        int                w;
        int                h;
        bit                col_last;
        bit                row_last;
        t_result           r;
        w = effective_dim(cfg_width, MAX_WIDTH);
        h = effective_dim(cfg_height, MAX_HEIGHT);
        col_last = col_count >= w - 1;
        row_last = row_count >= h - 1;
        bytes[0] = px.byte_zero;
        bytes[1] = px.byte_one;
        bytes[2] = px.byte_two;
        for (int c = 0; c < NUM_CH; c++) begin
            src = cfg_swap ? bytes[NUM_CH - 1 - c] : bytes[c];
            if (cfg_planar) begin
                r.element_address = ADDR_W'(c * h * w + row_count * w + col_count);
            end else begin
                r.element_address = ADDR_W'(row_count * int'(cfg_pitch) + 3 * col_count + c);
            end
            r.channel_value = normalized_value(src, cfg_norm[c]);
            r.channel_index = CH_W'(c);
            r.last_of_pixel = (c == NUM_CH - 1);
            r.frame_end     = (c == NUM_CH - 1) && col_last && row_last;
            expected_results.push_back(r);
        end
        if (col_last) begin
            col_count = 0;
            row_count = row_last ? 0 : row_count + 1;
        end else begin
            col_count++;
        end
    endfunction

    // Report one field that differs from its prediction.
    function automatic void check_field(input string name, input logic [VALUE_W-1:0] exp_val,
                                        input logic [VALUE_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    // Follow configuration writes, results and pixel requests at every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                cfg_norm[c] = '0;
            end
            cfg_swap   = 1'b0;
            cfg_planar = 1'b0;
            cfg_width  = RST_WIDTH;
            cfg_height = RST_HEIGHT;
            cfg_pitch  = RST_PITCH;
            col_count  = 0;
            row_count  = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NORM0, CFG_NORM1, CFG_NORM2: begin
                        cfg_norm[i_cfg_index] = i_cfg_data;
                    end
                    CFG_LAYOUT: begin
                        cfg_swap   = i_cfg_data[LAYOUT_SWAP_BIT];
                        cfg_planar = i_cfg_data[LAYOUT_PLANAR_BIT];
                    end
                    CFG_WIDTH:  cfg_width  = i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: cfg_height = i_cfg_data[DIM_W-1:0];
                    CFG_PITCH:  cfg_pitch  = i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing pending: address %0h, channel %0d",
                           i_result.element_address, i_result.channel_index);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("element_address", want.element_address,
                                i_result.element_address);
                    check_field("channel_value", want.channel_value, i_result.channel_value);
                    check_field("channel_index", want.channel_index, i_result.channel_index);
                    check_field("last_of_pixel", want.last_of_pixel, i_result.last_of_pixel);
                    check_field("frame_end", want.frame_end, i_result.frame_end);
                end
            end

            if (i_pix_valid && i_pix_ready) begin
                predict_channels(i_pixel);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the pixel normalizer and planarizer testbench: clock, reset, requests and verdict.
// Depends on pnp_pkg, pixel_normalize_and_planarize and pnp_result_checker.
module testbench;
    import pnp_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS = 20;
    localparam int LIMIT_NS = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;
    localparam logic [NORM_W-1:0] LAYOUT_SWAP = NORM_W'(1) << LAYOUT_SWAP_BIT;
    localparam logic [NORM_W-1:0] LAYOUT_PLANAR = NORM_W'(1) << LAYOUT_PLANAR_BIT;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_pixel               i_pixel;
    logic                 o_valid;
    logic                 i_ready;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [NORM_W-1:0]    i_cfg_data;
    int                   results_pending;
    int                   mismatches;
    bit                   rx_stall_en = 1'b1;

    pixel_normalize_and_planarize dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pnp_result_checker result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_pixel      (i_pixel),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (results_pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Directed pixels: all zeros, all ones, alternating patterns and mixed values.
    function automatic t_pixel corner_pixel(input int k);
        case (k)
            0:       return t_pixel'(24'h000000);
            1:       return t_pixel'(24'hFFFFFF);
            2:       return t_pixel'(24'hFF00FF);
            3:       return t_pixel'(24'h00FF00);
            4:       return t_pixel'(24'h807F01);
            default: return t_pixel'(24'hAA55FF);
        endcase
    endfunction

    // The result side accepts in runs, with random stalls between them when stalls are enabled.
    initial begin
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (rx_stall_en) begin
                i_ready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge i_clk);
            end
        end
    end

    // Offer one pixel, after an optional idle gap, and hold it until it is taken.
    task automatic send_pixel(input t_pixel px, input bit idle_on);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Write one register; the caller lowers the valid after its last write.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop offering pixels and wait until every predicted result has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_corners(input int count, input bit idle_on);
        for (int k = 0; k < count; k++) begin
            send_pixel(corner_pixel(k), idle_on);
        end
        drain();
    endtask

    initial begin : stimulus
        logic [NORM_W-1:0] norm;
        logic [DIM_W-1:0]  dim;
        t_pixel            px;
        bit                idle_on;
        bit                pause_mid;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_NORM0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: zero scale, 640 by 640 interleaved.
        send_corners(3, 1'b0);

        // Extreme means and scales on a 3 by 2 frame; the counter starts beyond the width.
        write_cfg(CFG_NORM0, {16'h0000, 24'h7FFFFF});
        write_cfg(CFG_NORM1, {16'hFFFF, 24'h800000});
        write_cfg(CFG_NORM2, {16'h8000, 24'h100000});
        write_cfg(CFG_LAYOUT, '0);
        write_cfg(CFG_WIDTH, 3);
        write_cfg(CFG_HEIGHT, 2);
        write_cfg(CFG_PITCH, 9);
        i_cfg_valid <= 1'b0;
        send_corners(6, 1'b1);

        // Same pixels, byte swap and planar layout.
        write_cfg(CFG_LAYOUT, LAYOUT_SWAP | LAYOUT_PLANAR);
        i_cfg_valid <= 1'b0;
        send_corners(6, 1'b0);

        // Zero sizes act as one pixel per frame; largest pitch.
        write_cfg(CFG_WIDTH, 0);
        write_cfg(CFG_HEIGHT, 0);
        write_cfg(CFG_PITCH, 8191);
        write_cfg(CFG_LAYOUT, LAYOUT_PLANAR);
        i_cfg_valid <= 1'b0;
        send_corners(3, 1'b1);

        // Oversized width is clipped; a write past the last register changes nothing.
        write_cfg(CFG_SPARE, '1);
        write_cfg(CFG_WIDTH, 4095);
        write_cfg(CFG_HEIGHT, 2048);
        write_cfg(CFG_PITCH, 0);
        write_cfg(CFG_LAYOUT, LAYOUT_SWAP);
        i_cfg_valid <= 1'b0;
        send_corners(3, 1'b0);

        // Random phases: fresh settings, then a run of random pixels.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if ($urandom_range(0, 3) == 0) begin
                    norm = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                            ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000)};
                end else begin
                    norm = NORM_W'({$urandom, $urandom});
                end
                write_cfg(t_cfg_idx'(CFG_NORM0 + c), norm);
            end
            write_cfg(CFG_LAYOUT, NORM_W'($urandom_range(0, 3)));
            // Sizes are mostly tiny so frames end often; sometimes left alone so the
            // counters carry over past a smaller frame.
            for (int k = 0; k < 2; k++) begin
                case ($urandom_range(0, 9))
                    0:       dim = '0;
                    1:       dim = '1;
                    2:       dim = DIM_W'($urandom_range(1, 4095));
                    default: dim = DIM_W'($urandom_range(1, 6));
                endcase
                if ($urandom_range(0, 3) != 0) begin
                    write_cfg(k == 0 ? CFG_WIDTH : CFG_HEIGHT, NORM_W'(dim));
                end
            end
            case ($urandom_range(0, 4))
                0:       write_cfg(CFG_PITCH, 0);
                1:       write_cfg(CFG_PITCH, 8191);
                2:       write_cfg(CFG_PITCH, NORM_W'($urandom_range(0, 8191)));
                default: write_cfg(CFG_PITCH, NORM_W'($urandom_range(3, 24)));
            endcase
            i_cfg_valid <= 1'b0;

            idle_on     = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            pause_mid   = (phase == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                if (pause_mid && k == PHASE_PIXELS / 2) begin
                    drain();
                end
                px = t_pixel'(24'($urandom));
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: ;
                endcase
                send_pixel(px, idle_on);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && results_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
